/* rtl/a2b_pkg.sv */
// ----------------------------------------------------------------------------
// a2b_pkg: shared types and constants for the accelerometer display path
// Axis codes, command codes, register map and the fixed-point constants.
// ----------------------------------------------------------------------------
package a2b_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned ScaleW  = 8;
  localparam int unsigned ProdW   = WordW + ScaleW;
  localparam int unsigned DigitW  = 4;

  localparam logic [ScaleW-1:0] SCALE_RESET = 8'd39;
  localparam logic [WordW-1:0]  SAT_LIMIT   = 16'hFFFF;

  // floor(p / 10) for 24-bit p: (p * ceil(2^27 / 10)) >> 27
  localparam logic [ProdW-1:0] RECIP10_P   = 24'hCCCCCD;
  localparam int unsigned      RECIP10_P_SH = 27;

  // Digit split of a 16-bit value: floor(s / 10^k) = (s * m_k) >> sh_k
  localparam int unsigned      MulW       = 34;
  localparam logic [MulW-1:0]  RECIP_1E1  = 34'd52429;
  localparam int unsigned      SH_1E1     = 19;
  localparam logic [MulW-1:0]  RECIP_1E2  = 34'd83887;
  localparam int unsigned      SH_1E2     = 23;
  localparam logic [MulW-1:0]  RECIP_1E3  = 34'd67109;
  localparam int unsigned      SH_1E3     = 26;
  localparam logic [MulW-1:0]  RECIP_1E4  = 34'd107375;
  localparam int unsigned      SH_1E4     = 30;

  // APB register map
  localparam int unsigned      ApbAddrW   = 3;
  localparam logic [0:0]       REG_SCALE  = 1'b0;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_BUTTON = 1'b1
  } cmd_e;

  // Sideband that travels with an item down the pipeline
  typedef struct packed {
    logic       sign;
    logic [1:0] axis;
  } tag_t;

endpackage

/* rtl/a2b_in_if.sv */
// ----------------------------------------------------------------------------
// a2b_in_if: input channel
// Carries a command bit and the three raw axis words with valid/ready.
// ----------------------------------------------------------------------------
interface a2b_in_if;
  import a2b_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WordW-1:0]  x_word;
  logic [WordW-1:0]  y_word;
  logic [WordW-1:0]  z_word;

  modport source (output valid, cmd, x_word, y_word, z_word, input ready);
  modport sink   (input valid, cmd, x_word, y_word, z_word, output ready);
endinterface

/* rtl/a2b_out_if.sv */
// ----------------------------------------------------------------------------
// a2b_out_if: display channel
// Carries five decimal digits, the sign lamp and the shown axis.
// ----------------------------------------------------------------------------
interface a2b_out_if;
  import a2b_pkg::*;

  logic              valid;
  logic              ready;
  logic [DigitW-1:0] digit_units;
  logic [DigitW-1:0] digit_tens;
  logic [DigitW-1:0] digit_hundreds;
  logic [DigitW-1:0] digit_thousands;
  logic [DigitW-1:0] digit_ten_thousands;
  logic              sign_lamp;
  logic [1:0]        shown_axis;

  modport source (output valid, digit_units, digit_tens, digit_hundreds,
                  digit_thousands, digit_ten_thousands, sign_lamp, shown_axis,
                  input ready);
  modport sink   (input valid, digit_units, digit_tens, digit_hundreds,
                  digit_thousands, digit_ten_thousands, sign_lamp, shown_axis,
                  output ready);
endinterface

/* rtl/a2b_digits.sv */
// ----------------------------------------------------------------------------
// a2b_digits: 16-bit binary to five BCD digits
// Two stages: reciprocal quotients by powers of ten, then digit remainders.
// ----------------------------------------------------------------------------
module a2b_digits (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [15:0]          scaled_i,
  input  a2b_pkg::tag_t        tag_i,
  a2b_out_if.source            disp_o
);
  import a2b_pkg::*;

  logic                   q_v_q;
  logic [WordW-1:0]       quo_q [5];
  logic [WordW-1:0]       quo_d [5];
  tag_t                   q_tag_q;
  logic [MulW-1:0]        m1, m2, m3, m4;
  logic                   adv_quo, adv_dig;

  logic                   o_v_q;
  logic [DigitW-1:0]      dig_q [5];
  logic [DigitW-1:0]      dig_d [5];
  tag_t                   o_tag_q;

  assign adv_dig = !o_v_q || disp_o.ready;
  assign adv_quo = !q_v_q || adv_dig;
  assign ready_o = adv_quo;

  always_comb begin
    m1 = MulW'(scaled_i) * RECIP_1E1;
    m2 = MulW'(scaled_i) * RECIP_1E2;
    m3 = MulW'(scaled_i) * RECIP_1E3;
    m4 = MulW'(scaled_i) * RECIP_1E4;
    quo_d[0] = scaled_i;
    quo_d[1] = WordW'(m1 >> SH_1E1);
    quo_d[2] = WordW'(m2 >> SH_1E2);
    quo_d[3] = WordW'(m3 >> SH_1E3);
    quo_d[4] = WordW'(m4 >> SH_1E4);
  end

  // digit k = q_k - 10 * q_(k+1); the result is below ten, so four bits suffice
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dig_d[k] = DigitW'(quo_q[k] - (quo_q[k+1] << 3) - (quo_q[k+1] << 1));
    end
    dig_d[4] = DigitW'(quo_q[4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (adv_quo) q_v_q <= valid_i;
      if (adv_dig) o_v_q <= q_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_quo && valid_i) begin
      quo_q   <= quo_d;
      q_tag_q <= tag_i;
    end
    if (adv_dig && q_v_q) begin
      dig_q   <= dig_d;
      o_tag_q <= q_tag_q;
    end
  end

  assign disp_o.valid               = o_v_q;
  assign disp_o.digit_units         = dig_q[0];
  assign disp_o.digit_tens          = dig_q[1];
  assign disp_o.digit_hundreds      = dig_q[2];
  assign disp_o.digit_thousands     = dig_q[3];
  assign disp_o.digit_ten_thousands = dig_q[4];
  assign disp_o.sign_lamp           = o_tag_q.sign;
  assign disp_o.shown_axis          = o_tag_q.axis;

endmodule

/* rtl/accel_axis_to_bcd_display.sv */
// ----------------------------------------------------------------------------
// accel_axis_to_bcd_display: accelerometer axis to decimal display
// Picks one axis, takes its magnitude, scales by tenths of mg, saturates and
// splits the value into five BCD digits with a sign lamp.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the display is ready; five registered
//   stages (magnitude, product, scaled value, quotients, digits), one
//   multiplier each for scale and divide by ten, four in parallel for the
//   digit quotients. Button items update the axis selector, give no result.
// Reset: async active low; selector to X, scale to 3.9, pipeline emptied.
// ----------------------------------------------------------------------------
module accel_axis_to_bcd_display (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  a2b_in_if.sink                        sample_i,
  a2b_out_if.source                     disp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [a2b_pkg::ApbAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import a2b_pkg::*;

  logic [ScaleW-1:0]  scale_q;
  axis_e              axis_q, axis_d;
  logic               cfg_wr;

  logic               in_fire;
  logic               adv0, adv1, adv2, dig_ready;
  axis_e              axis_eff;
  logic [WordW-1:0]   word;
  logic [WordW-1:0]   mag_d;

  logic               s0_v_q, s1_v_q, s2_v_q;
  logic [WordW-1:0]   mag_q;
  tag_t               tag0_q, tag1_q, tag2_q;
  logic [ProdW-1:0]   prod_q;
  logic [2*ProdW-1:0] quot_full;
  logic [19:0]        quot;
  logic [WordW-1:0]   scaled_d, scaled_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ApbAddrW-1] == REG_SCALE);
  assign prdata = (paddr[ApbAddrW-1] == REG_SCALE) ? 32'(scale_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_wr) begin
      scale_q <= pwdata[ScaleW-1:0];
    end
  end

  // ---------------- axis selector ----------------
  assign adv2    = !s2_v_q || dig_ready;
  assign adv1    = !s1_v_q || adv2;
  assign adv0    = !s0_v_q || adv1;
  assign sample_i.ready = adv0;
  assign in_fire = sample_i.valid && adv0;

  always_comb begin
    unique case (axis_q)
      AXIS_X:  axis_d = AXIS_Y;
      AXIS_Y:  axis_d = AXIS_Z;
      AXIS_Z:  axis_d = AXIS_X;
      default: axis_d = AXIS_Y;
    endcase
  end

  always_comb begin
    case (axis_q)
      AXIS_Y:  begin axis_eff = AXIS_Y; word = sample_i.y_word; end
      AXIS_Z:  begin axis_eff = AXIS_Z; word = sample_i.z_word; end
      default: begin axis_eff = AXIS_X; word = sample_i.x_word; end
    endcase
    // 0x8000 wraps to itself, i.e. magnitude 32768
    mag_d = word[WordW-1] ? (~word + 1'b1) : word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_X;
    end else if (in_fire && (sample_i.cmd == CMD_BUTTON)) begin
      axis_q <= axis_d;
    end
  end

  // ---------------- pipeline control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      // drop button items here: they carry no result
      if (adv0) s0_v_q <= in_fire && (sample_i.cmd == CMD_SAMPLE);
      if (adv1) s1_v_q <= s0_v_q;
      if (adv2) s2_v_q <= s1_v_q;
    end
  end

  // ---------------- datapath ----------------
  assign quot_full = (2*ProdW)'(prod_q) * (2*ProdW)'(RECIP10_P);
  assign quot      = 20'(quot_full >> RECIP10_P_SH);
  assign scaled_d  = (quot > 20'(SAT_LIMIT)) ? SAT_LIMIT : quot[WordW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire && (sample_i.cmd == CMD_SAMPLE)) begin
      mag_q       <= mag_d;
      tag0_q.sign <= word[WordW-1];
      tag0_q.axis <= axis_eff;
    end
    if (adv1 && s0_v_q) begin
      prod_q <= ProdW'(mag_q) * ProdW'(scale_q);
      tag1_q <= tag0_q;
    end
    if (adv2 && s1_v_q) begin
      scaled_q <= scaled_d;
      tag2_q   <= tag1_q;
    end
  end

  a2b_digits u_digits (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_v_q),
    .ready_o  (dig_ready),
    .scaled_i (scaled_q),
    .tag_i    (tag2_q),
    .disp_o   (disp_o)
  );

endmodule
